FILE: sv/msfade_pkg.sv
// ----------------------------------------------------------------------------
// msfade_pkg
// Types and constants shared by the multi-slot eased fade engine.
// ----------------------------------------------------------------------------
package msfade_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int ALPHA_FRAC_BITS = 12;
  localparam int ALPHA_W         = 13;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC_BITS);
  localparam logic [16:0] Q_ONE  = 17'd65536;
  localparam logic [16:0] Q_HALF = 17'd32768;
  localparam int LEN_W           = 26;
  localparam int US_PER_MS       = 1000;
  localparam int SLOTS_IN_USE_RST = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] EASE_LINEAR   = 2'd0;
  localparam logic [1:0] EASE_OUT_QUAD = 2'd1;
  localparam logic [1:0] EASE_IO_CUBIC = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_EASE,
    ST_BLEND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  slot;
    logic [12:0] target_alpha;
    logic [15:0] duration_ms;
    logic [1:0]  easing;
    logic [31:0] now_us;
  } req_t;

  typedef struct packed {
    logic [3:0]  which_slot;
    logic [12:0] alpha_now;
    logic        finished;
    logic [4:0]  active_count;
    logic        last;
  } rsp_t;

endpackage

FILE: sv/multi_slot_eased_fade_engine.sv
// ----------------------------------------------------------------------------
// multi_slot_eased_fade_engine
// Bank of fade slots that move an alpha toward a target along an easing curve.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel either starts a transition on one
// slot (opcode 0) or is a frame tick (opcode 1). A start is taken while
// idle and produces nothing. A tick walks the enabled slots in index order
// and sends one result per active slot on the output channel, the final
// one flagged with last. The input is not ready while a tick is being walked.
// Steps of a tick: each enabled slot is visited in a scan state, and one
// more scan ends the walk; an active slot then runs the shared restoring
// divider (skipped when it finishes), two or three passes through the shared
// multiplier, an easing state and an emit state. Most of a tick's time is
// spent in the divider iterations.
// While the receiver stalls, the result is held on the output and the walk
// pauses. Reset clears all slots, the active count, and sets slots_in_use
// to 16; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module multi_slot_eased_fade_engine #(
  parameter int SLOTS = msfade_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  msfade_pkg::req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output msfade_pkg::rsp_t  out_data,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_data
);
  import msfade_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;

  logic [ALPHA_W-1:0] start_alpha [SLOTS];
  logic [ALPHA_W-1:0] goal_alpha  [SLOTS];
  logic [ALPHA_W-1:0] shown_alpha [SLOTS];
  logic [31:0]        start_time  [SLOTS];
  logic [LEN_W-1:0]   length_us   [SLOTS];
  logic [1:0]         curve_kind  [SLOTS];
  logic [SLOTS-1:0]   slot_active;
  logic [CW-1:0]      running_count;
  logic [4:0]         slots_in_use;

  logic [CW-1:0]      idx;
  logic [31:0]        now_reg;
  logic [LEN_W:0]     rem;
  logic [LEN_W-1:0]   len_reg;
  logic [15:0]        quot;
  logic [4:0]         div_cnt;
  logic [16:0]        t_reg;
  logic [16:0]        e_reg;
  logic               done_reg;
  logic [50:0]        prod;

  logic [IW-1:0]      cur;
  logic [IW-1:0]      st_idx;
  logic               walk_end;
  logic [31:0]        elapsed;
  logic               slot_done;
  logic [LEN_W:0]     rem_sh;
  logic               div_last;
  logic [16:0]        base;
  logic [33:0]        mul_a;
  logic [16:0]        mul_b;
  logic [ALPHA_W-1:0] diff;
  logic               rising;
  logic [ALPHA_W-1:0] step;
  logic [ALPHA_W-1:0] new_alpha;
  logic               more_after;
  logic [ALPHA_W-1:0] tgt_clamped;
  logic               start_ok;
  logic [CW-1:0]      count_after;

  assign cur      = idx[IW-1:0];
  assign st_idx   = IW'(in_data.slot);
  assign walk_end = (int'(idx) >= SLOTS) || (int'(idx) >= int'(slots_in_use));
  assign elapsed  = now_reg - start_time[cur];
  assign slot_done = (length_us[cur] == '0) ||
                     (elapsed >= 32'(length_us[cur]));
  assign rem_sh   = {rem[LEN_W-1:0], 1'b0};
  assign div_last = (div_cnt == 5'd15);
  assign start_ok = (int'(in_data.slot) < SLOTS) &&
                    (int'(in_data.slot) < int'(slots_in_use));
  assign tgt_clamped = (in_data.target_alpha > ALPHA_ONE) ? ALPHA_ONE
                                                          : in_data.target_alpha;

  // Operand of the easing polynomial for the current curve.
  always_comb begin
    case (curve_kind[cur])
      EASE_OUT_QUAD: base = Q_ONE - t_reg;
      EASE_IO_CUBIC: base = (t_reg < Q_HALF) ? t_reg
                                             : 17'((Q_ONE - t_reg) << 1);
      default:       base = t_reg;
    endcase
  end

  assign rising = goal_alpha[cur] >= start_alpha[cur];
  assign diff   = rising ? (goal_alpha[cur] - start_alpha[cur])
                         : (start_alpha[cur] - goal_alpha[cur]);
  assign step   = ALPHA_W'(prod[50:16]);
  assign new_alpha = rising ? (start_alpha[cur] + step) : (start_alpha[cur] - step);
  assign count_after = (done_reg && running_count != '0) ? running_count - 1'b1
                                                         : running_count;

  // Any further active, enabled slot after the current one.
  always_comb begin
    more_after = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (j > int'(idx) && j < int'(slots_in_use) && slot_active[j])
        more_after = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && in_data.opcode == OP_TICK) state_next = ST_SCAN;
      ST_SCAN: begin
        if (walk_end)               state_next = ST_IDLE;
        else if (!slot_active[cur]) state_next = ST_SCAN;
        else if (slot_done)         state_next = ST_MUL1;
        else                        state_next = ST_DIV;
      end
      ST_DIV:   if (div_last) state_next = ST_MUL1;
      ST_MUL1:  state_next = (curve_kind[cur] == EASE_IO_CUBIC) ? ST_MUL2 : ST_EASE;
      ST_MUL2:  state_next = ST_EASE;
      ST_EASE:  state_next = ST_BLEND;
      ST_BLEND: state_next = ST_EMIT;
      ST_EMIT:  if (out_ready) state_next = ST_SCAN;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs and multiplier operand selection.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
    mul_a = 34'(base);
    mul_b = base;
    case (state)
      ST_MUL2:  mul_a = prod[33:0];
      ST_BLEND: begin
        mul_a = 34'(diff);
        mul_b = e_reg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_active   <= '0;
      running_count <= '0;
      slots_in_use  <= 5'(SLOTS_IN_USE_RST);
      idx           <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        start_alpha[k] <= '0;
        goal_alpha[k]  <= '0;
        shown_alpha[k] <= '0;
        start_time[k]  <= '0;
        length_us[k]   <= '0;
        curve_kind[k]  <= EASE_LINEAR;
      end
    end else begin
      state <= state_next;
      if (cfg_we) slots_in_use <= cfg_data;

      case (state)
        ST_IDLE: begin
          idx     <= '0;
          now_reg <= in_data.now_us;
          if (in_valid && in_data.opcode == OP_START && start_ok) begin
            start_alpha[st_idx] <= shown_alpha[st_idx];
            goal_alpha[st_idx]  <= tgt_clamped;
            start_time[st_idx]  <= in_data.now_us;
            length_us[st_idx]   <= LEN_W'(in_data.duration_ms * US_PER_MS);
            curve_kind[st_idx]  <= in_data.easing;
            slot_active[st_idx] <= (shown_alpha[st_idx] != tgt_clamped);
            if (shown_alpha[st_idx] != tgt_clamped && !slot_active[st_idx])
              running_count <= running_count + 1'b1;
            else if (shown_alpha[st_idx] == tgt_clamped && slot_active[st_idx] &&
                     running_count != '0)
              running_count <= running_count - 1'b1;
          end
        end
        ST_SCAN: begin
          if (!walk_end) begin
            if (!slot_active[cur]) idx <= idx + 1'b1;
            done_reg <= slot_done;
            t_reg    <= Q_ONE;
            rem      <= {1'b0, elapsed[LEN_W-1:0]};
            len_reg  <= length_us[cur];
            div_cnt  <= '0;
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem_sh >= {1'b0, len_reg}) begin
            rem  <= rem_sh - {1'b0, len_reg};
            quot <= {quot[14:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            quot <= {quot[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_last)
            t_reg <= {1'b0, quot[14:0], (rem_sh >= {1'b0, len_reg})};
        end
        ST_MUL1, ST_MUL2, ST_BLEND: prod <= 51'(mul_a * mul_b);
        ST_EASE: begin
          case (curve_kind[cur])
            EASE_OUT_QUAD: e_reg <= Q_ONE - 17'(prod >> 16);
            EASE_IO_CUBIC: e_reg <= (t_reg < Q_HALF) ? 17'(prod >> 30)
                                                     : Q_ONE - 17'(prod >> 33);
            default:       e_reg <= t_reg;
          endcase
        end
        ST_EMIT: begin
          if (out_ready) idx <= idx + 1'b1;
        end
        default: ;
      endcase

      // The blended alpha and the count are committed when the result is taken.
      if (state == ST_EMIT && out_ready) begin
        shown_alpha[cur] <= out_data.alpha_now;
        if (done_reg) begin
          slot_active[cur] <= 1'b0;
          running_count    <= count_after;
        end
      end
    end
  end

  always_comb begin
    out_data.which_slot   = 4'(idx);
    out_data.alpha_now    = new_alpha;
    out_data.finished     = done_reg;
    out_data.active_count = 5'(count_after);
    out_data.last         = !more_after;
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Fade engine testbench
// Drives start and tick requests into the multi-slot fade engine, predicts
// every tick result with a bit-accurate model of the easing and blending,
// and compares the results field by field under varying idle and stall rates.
// ----------------------------------------------------------------------------
module testbench;
  import msfade_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  logic cfg_we;
  logic [4:0] cfg_data;

  // Predictor state.
  logic [12:0] p_from [NSLOT];
  logic [12:0] p_goal [NSLOT];
  logic [12:0] p_shown [NSLOT];
  logic [31:0] p_t0 [NSLOT];
  logic [31:0] p_len [NSLOT];
  logic [1:0]  p_curve [NSLOT];
  logic        p_on [NSLOT];
  logic [4:0]  p_running;
  logic [4:0]  p_enabled;

  rsp_t alpha_queue[$];
  int errors;
  int results_seen;
  int requests_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;
  longint cycles;
  logic [31:0] clock_us;

  multi_slot_eased_fade_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [16:0] eased_progress(logic [16:0] t, logic [1:0] kind);
    logic [63:0] u;
    logic [63:0] tt;
    tt = 64'(t);
    if (kind == EASE_OUT_QUAD) begin
      u = 64'd65536 - tt;
      return 17'(64'd65536 - ((u * u) >> 16));
    end
    if (kind == EASE_IO_CUBIC) begin
      if (tt < 64'd32768) return 17'((64'd4 * tt * tt * tt) >> 32);
      u = 64'd2 * (64'd65536 - tt);
      return 17'(64'd65536 - ((u * u * u) >> 33));
    end
    return t;
  endfunction

  function automatic logic [12:0] blended_alpha(logic [12:0] a, logic [12:0] b,
                                                logic [16:0] e);
    logic [63:0] step;
    if (b >= a) begin
      step = (64'(b - a) * 64'(e)) >> 16;
      return a + 13'(step);
    end
    step = (64'(a - b) * 64'(e)) >> 16;
    return a - 13'(step);
  endfunction

  function automatic int enabled_limit();
    return (p_enabled < NSLOT) ? int'(p_enabled) : NSLOT;
  endfunction

  task automatic predict_fade(req_t r);
    int lim;
    int n;
    logic [12:0] tgt;
    logic        was;
    logic [31:0] elapsed;
    logic        done;
    logic [16:0] t;
    rsp_t rsp;
    lim = enabled_limit();
    n = 0;
    if (r.opcode == OP_START) begin
      if (int'(r.slot) >= lim) return;
      tgt = (r.target_alpha > ALPHA_ONE) ? ALPHA_ONE : r.target_alpha;
      was = p_on[r.slot];
      p_from[r.slot] = p_shown[r.slot];
      p_goal[r.slot] = tgt;
      p_t0[r.slot] = r.now_us;
      p_len[r.slot] = 32'(r.duration_ms) * 32'd1000;
      p_curve[r.slot] = r.easing;
      p_on[r.slot] = (p_shown[r.slot] != tgt);
      if (p_on[r.slot] && !was) p_running++;
      else if (!p_on[r.slot] && was && p_running > 0) p_running--;
      return;
    end
    for (int i = 0; i < lim; i++) begin
      if (!p_on[i]) continue;
      elapsed = r.now_us - p_t0[i];
      done = (p_len[i] == 0) || (elapsed >= p_len[i]);
      if (done) begin
        t = Q_ONE;
        p_on[i] = 1'b0;
        if (p_running > 0) p_running--;
      end else begin
        t = 17'((64'(elapsed) << 16) / 64'(p_len[i]));
      end
      p_shown[i] = blended_alpha(p_from[i], p_goal[i], eased_progress(t, p_curve[i]));
      rsp.which_slot = 4'(i);
      rsp.alpha_now = p_shown[i];
      rsp.finished = done;
      rsp.active_count = p_running;
      rsp.last = 1'b0;
      alpha_queue.push_back(rsp);
      n++;
    end
    if (n > 0) alpha_queue[alpha_queue.size()-1].last = 1'b1;
  endtask

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (alpha_queue.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %p", $time, out_data);
      end else begin
        exp_r = alpha_queue.pop_front();
        if (out_data.which_slot !== exp_r.which_slot) begin
          errors++;
          $display("%0t: which_slot expected %0d actual %0d", $time,
                   exp_r.which_slot, out_data.which_slot);
        end
        if (out_data.alpha_now !== exp_r.alpha_now) begin
          errors++;
          $display("%0t: alpha_now expected %0d actual %0d", $time,
                   exp_r.alpha_now, out_data.alpha_now);
        end
        if (out_data.finished !== exp_r.finished) begin
          errors++;
          $display("%0t: finished expected %0d actual %0d", $time,
                   exp_r.finished, out_data.finished);
        end
        if (out_data.active_count !== exp_r.active_count) begin
          errors++;
          $display("%0t: active_count expected %0d actual %0d", $time,
                   exp_r.active_count, out_data.active_count);
        end
        if (out_data.last !== exp_r.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time,
                   exp_r.last, out_data.last);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted down here.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Valid stays high after acceptance until the next request or an idle cycle
  // takes its place, so it is driven only once per time step.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_fade(r);
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (alpha_queue.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_slots_in_use(logic [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    p_enabled = v;
  endtask

  function automatic req_t start_req(int s, int tgt, int ms, int ease, logic [31:0] now);
    req_t r;
    r.opcode = OP_START;
    r.slot = 4'(s);
    r.target_alpha = 13'(tgt);
    r.duration_ms = 16'(ms);
    r.easing = 2'(ease);
    r.now_us = now;
    return r;
  endfunction

  function automatic req_t tick_req(logic [31:0] now);
    req_t r;
    r = req_t'({$urandom, $urandom});
    r.opcode = OP_TICK;
    r.now_us = now;
    return r;
  endfunction

  task automatic test_directed();
    send_request(tick_req(32'd5));
    send_request(start_req(0, 4096, 0, EASE_LINEAR, 32'd0));
    send_request(start_req(1, 8191, 65535, EASE_OUT_QUAD, 32'hFFFF_FF00));
    send_request(start_req(2, 2000, 1, EASE_IO_CUBIC, 32'd0));
    send_request(start_req(3, 3000, 2, 3, 32'd0));
    send_request(start_req(15, 100, 1, EASE_LINEAR, 32'd0));
    send_request(tick_req(32'd400));
    send_request(tick_req(32'd1200));
    send_request(start_req(4, 0, 5, EASE_LINEAR, 32'd0));
    send_request(start_req(3, 1000, 3, EASE_IO_CUBIC, 32'd1200));
    send_request(tick_req(32'd100));
    send_request(tick_req(32'd3000));
    send_request(start_req(2, 2000, 4, EASE_LINEAR, 32'd0));
    send_request(start_req(0, 0, 0, EASE_OUT_QUAD, 32'hFFFF_FFFF));
    send_request(tick_req(32'd5000));
    send_request(tick_req(32'hFFFF_FFFF));
  endtask

  task automatic random_phase(int n, int idle, int stall);
    int s;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      clock_us = clock_us + $urandom_range(3000);
      if ($urandom_range(2) == 0) begin
        send_request(tick_req(clock_us));
      end else begin
        s = (p_enabled < NSLOT && $urandom_range(3) == 0) ?
            $urandom_range(15) : $urandom_range(enabled_limit() - 1);
        send_request(start_req(s,
          ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(4096),
          ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(8),
          $urandom_range(3), clock_us - $urandom_range(50)));
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int s = 0; s < NSLOT; s++)
      send_request(start_req(s, 4096 - s, 10, s % 3, clock_us));
    hold_off = 600;
    send_request(tick_req(clock_us + 3000));
    send_request(tick_req(clock_us + 6000));
    send_request(tick_req(clock_us + 20000));
    clock_us = clock_us + 20000;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = 5'd0;
    errors = 0;
    results_seen = 0;
    requests_sent = 0;
    cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_us = 32'd10000;
    for (int i = 0; i < NSLOT; i++) begin
      p_from[i] = '0; p_goal[i] = '0; p_shown[i] = '0; p_t0[i] = '0;
      p_len[i] = '0; p_curve[i] = '0; p_on[i] = 1'b0;
    end
    p_running = '0;
    p_enabled = 5'd16;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_slots_in_use(5'd1);
    random_phase(15, 0, 0);
    write_slots_in_use(5'd0);
    random_phase(5, 0, 0);
    write_slots_in_use(5'd31);
    random_phase(30, 83, 0);
    write_slots_in_use(5'd6);
    random_phase(30, 0, 83);
    write_slots_in_use(5'd16);
    random_phase(30, 32, 32);
    test_backpressure();
    random_phase(20, 0, 0);
    drain();
    $display("Sent %0d requests covering starts, ticks and slot-count changes.",
             requests_sent);
    $display("Checked %0d tick results under idle, stall and hold-off phases.",
             results_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
